@@ src/pc2p_pkg.sv @@
// Shared types and field widths for the palette chunky-to-planar converter.
package pc2p_pkg;

  localparam int OPCODE_W = 2;
  localparam int PIXEL_W  = 12;
  localparam int SLOT_W   = 4;
  localparam int INDEX_W  = 4;   // four bitplanes
  localparam int PLANES   = 4;
  localparam int PLANE_W  = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PIXEL = 2'd0,
    OP_LOCK  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

endpackage

@@ src/palette_chunky_to_planar_core.sv @@
// Palette chunky-to-planar converter: palette lookup and four-bitplane packing.
//
// Rate: one request per clock cycle, sustained. A request is captured in an input
// register, looked up against all palette slots at once (parallel compare plus a
// priority encode of the lowest hit or lowest free slot) and, on every
// GROUP_PIXELS-th pixel, the four plane words land in the result register. out_tvalid
// rises once the last pixel of a group has moved from the input register into the
// result register. The input side stalls only while the result register holds an
// untaken group and out_tready is low.
// in_tuser carries the opcode (0 pixel, 1 lock colour at slot, 2 clear palette and
// group; 3 is ignored). Rows must be padded by the sender to whole pixel groups.
module palette_chunky_to_planar_core #(
  parameter int PALETTE_SLOTS = 16,
  parameter int COLOR_BITS    = 12,
  parameter int GROUP_PIXELS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] pixel_color, [15:12] slot_index
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] plane_zero, [31:16] plane_one,
                                  // [47:32] plane_two, [63:48] plane_three
  output logic        out_tuser   // [0] palette_overflow
);

  localparam int PW = pc2p_pkg::PLANE_W;
  localparam int NP = pc2p_pkg::PLANES;

  // input register
  logic                         s1_valid_r;
  logic [pc2p_pkg::OPCODE_W-1:0] s1_op_r;
  logic [pc2p_pkg::PIXEL_W-1:0]  s1_color_r;
  logic [pc2p_pkg::SLOT_W-1:0]   s1_slot_r;

  // palette and group state
  logic [COLOR_BITS-1:0]   slot_color_r [PALETTE_SLOTS];
  logic [PALETTE_SLOTS-1:0] slot_valid_r, slot_valid_nxt;
  logic [GROUP_PIXELS-1:0] plane_r [NP];
  logic [GROUP_PIXELS-1:0] plane_nxt [NP];
  logic [3:0]              count_r, count_nxt;
  logic                    ovf_r, ovf_nxt;

  // result register
  logic                 out_valid_r;
  logic [NP*PW-1:0]     out_data_r;
  logic                 out_ovf_r;

  logic                 s1_go;
  logic                 emit;
  logic [COLOR_BITS-1:0] color;
  logic [PALETTE_SLOTS-1:0] hit, free_slot, fill;
  logic                 any_hit, any_free;
  logic [pc2p_pkg::INDEX_W-1:0] hit_idx, free_idx, idx;
  logic [NP*PW-1:0]     out_data_nxt;

  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ovf_r;

  // pixel_color masked to the configured colour width
  assign color = COLOR_BITS'({4'b0000, s1_color_r});

  always_comb begin
    hit_idx   = '0;
    free_idx  = '0;
    for (int i = PALETTE_SLOTS - 1; i >= 0; i--) begin
      hit[i]       = slot_valid_r[i] && (slot_color_r[i] == color);
      free_slot[i] = !slot_valid_r[i];
      if (hit[i]) begin
        hit_idx = pc2p_pkg::INDEX_W'(i);
      end
      if (free_slot[i]) begin
        free_idx = pc2p_pkg::INDEX_W'(i);
      end
    end
    any_hit  = |hit;
    any_free = |free_slot;
    idx      = any_hit ? hit_idx : (any_free ? free_idx : '0);
  end

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    fill           = '0;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    emit           = 1'b0;
    out_data_nxt   = '0;
    for (int p = 0; p < NP; p++) begin
      plane_nxt[p] = plane_r[p];
    end
    case (pc2p_pkg::opcode_t'(s1_op_r))
      pc2p_pkg::OP_PIXEL: begin
        if (!any_hit && any_free) begin
          for (int i = 0; i < PALETTE_SLOTS; i++) begin
            fill[i] = (free_idx == pc2p_pkg::INDEX_W'(i));
          end
          slot_valid_nxt = slot_valid_r | fill;
        end
        if (!any_hit && !any_free) begin
          ovf_nxt = 1'b1;
        end
        for (int p = 0; p < NP; p++) begin
          plane_nxt[p] = {plane_r[p][GROUP_PIXELS-2:0], idx[p]};
          out_data_nxt[p*PW +: PW] = PW'(plane_nxt[p]);
        end
        if (count_r == 4'(GROUP_PIXELS - 1)) begin
          emit      = 1'b1;
          count_nxt = '0;
          for (int p = 0; p < NP; p++) begin
            plane_nxt[p] = '0;
          end
        end else begin
          count_nxt = count_r + 4'd1;
        end
      end
      pc2p_pkg::OP_LOCK: begin
        for (int i = 0; i < PALETTE_SLOTS; i++) begin
          fill[i] = (s1_slot_r == pc2p_pkg::SLOT_W'(i));
        end
        slot_valid_nxt = slot_valid_r | fill;
      end
      pc2p_pkg::OP_CLEAR: begin
        slot_valid_nxt = '0;
        count_nxt      = '0;
        ovf_nxt        = 1'b0;
        for (int p = 0; p < NP; p++) begin
          plane_nxt[p] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      slot_valid_r <= '0;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      for (int p = 0; p < NP; p++) begin
        plane_r[p] <= '0;
      end
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_go && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_go) begin
        slot_valid_r <= slot_valid_nxt;
        count_r      <= count_nxt;
        ovf_r        <= ovf_nxt;
        for (int p = 0; p < NP; p++) begin
          plane_r[p] <= plane_nxt[p];
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r    <= in_tuser;
      s1_color_r <= in_tdata[pc2p_pkg::PIXEL_W-1:0];
      s1_slot_r  <= in_tdata[pc2p_pkg::PIXEL_W +: pc2p_pkg::SLOT_W];
    end
    if (s1_go) begin
      for (int i = 0; i < PALETTE_SLOTS; i++) begin
        if (fill[i]) begin
          slot_color_r[i] <= color;
        end
      end
      if (emit) begin
        out_data_r <= out_data_nxt;
        out_ovf_r  <= ovf_nxt;
      end
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench for palette_chunky_to_planar_core: directed and random requests checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 16;
  localparam int GROUP       = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int POOL_MAX    = 24;
  localparam logic [pc2p_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic                                          overflow;
    logic [pc2p_pkg::PLANES*pc2p_pkg::PLANE_W-1:0] words;
  } plane_group_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;

  always #1 clk = ~clk;

  palette_chunky_to_planar_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // predicted palette and group state
  logic [pc2p_pkg::PIXEL_W-1:0] pal_color [SLOTS];
  logic                         pal_used  [SLOTS];
  logic [pc2p_pkg::PLANE_W-1:0] plane_acc [pc2p_pkg::PLANES];
  int unsigned                  pixel_count;
  logic                         overflow_flag;
  plane_group_t                 pending_groups [$];

  string plane_name [pc2p_pkg::PLANES] =
    '{"plane_zero", "plane_one", "plane_two", "plane_three"};

  bit          calm = 1'b0;
  int unsigned errors, idle_cycles, out_hold;
  int unsigned n_requests, n_pixels, n_groups, n_ovf_groups, n_locks, n_clears, n_ignored;

  function automatic void restart_group();
    for (int p = 0; p < pc2p_pkg::PLANES; p++) plane_acc[p] = '0;
    pixel_count = 0;
  endfunction

  function automatic void clear_palette();
    for (int i = 0; i < SLOTS; i++) pal_used[i] = 1'b0;
    overflow_flag = 1'b0;
    restart_group();
  endfunction

  function automatic void predict_planes(logic [pc2p_pkg::OPCODE_W-1:0] op,
                                         logic [pc2p_pkg::PIXEL_W-1:0] color,
                                         logic [pc2p_pkg::SLOT_W-1:0] slot);
    logic [pc2p_pkg::INDEX_W-1:0] idx;
    logic                         hit;
    plane_group_t                 grp;
    idx = '0;
    hit = 1'b0;
    case (op)
      pc2p_pkg::OP_LOCK: begin
        if (slot < SLOTS) begin
          pal_color[slot] = color;
          pal_used[slot]  = 1'b1;
        end
      end
      pc2p_pkg::OP_CLEAR: begin
        clear_palette();
      end
      pc2p_pkg::OP_PIXEL: begin
        // lowest matching slot wins, then lowest free slot
        for (int i = 0; i < SLOTS; i++)
          if (!hit && pal_used[i] && pal_color[i] == color) begin
            idx = pc2p_pkg::INDEX_W'(i);
            hit = 1'b1;
          end
        for (int i = 0; i < SLOTS; i++)
          if (!hit && !pal_used[i]) begin
            pal_used[i]  = 1'b1;
            pal_color[i] = color;
            idx = pc2p_pkg::INDEX_W'(i);
            hit = 1'b1;
          end
        if (!hit) overflow_flag = 1'b1;  // full palette maps to index 0
        for (int p = 0; p < pc2p_pkg::PLANES; p++)
          plane_acc[p] = {plane_acc[p][pc2p_pkg::PLANE_W-2:0], idx[p]};
        pixel_count++;
        if (pixel_count == GROUP) begin
          for (int p = 0; p < pc2p_pkg::PLANES; p++)
            grp.words[p*pc2p_pkg::PLANE_W +: pc2p_pkg::PLANE_W] = plane_acc[p];
          grp.overflow = overflow_flag;
          pending_groups.push_back(grp);
          n_groups++;
          if (overflow_flag) n_ovf_groups++;
          restart_group();
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(logic [pc2p_pkg::OPCODE_W-1:0] op,
                              logic [pc2p_pkg::PIXEL_W-1:0] color,
                              logic [pc2p_pkg::SLOT_W-1:0] slot);
    bit ready_seen;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= {slot, color};
    in_tvalid <= 1'b1;
    // ready is stable between the falling edge and the next rising edge
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    predict_planes(op, color, slot);
    case (op)
      pc2p_pkg::OP_PIXEL: n_pixels++;
      pc2p_pkg::OP_LOCK:  n_locks++;
      pc2p_pkg::OP_CLEAR: n_clears++;
      default:            n_ignored++;
    endcase
    if (op != OP_UNUSED) n_requests++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
  endtask

  function automatic void note_failure(string msg);
    errors++;
    if (errors <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endfunction

  function automatic void check_group();
    plane_group_t want;
    if (pending_groups.size() == 0) begin
      note_failure($sformatf("unexpected group tdata=%h tuser=%b", out_tdata, out_tuser));
      return;
    end
    want = pending_groups.pop_front();
    for (int p = 0; p < pc2p_pkg::PLANES; p++)
      if (want.words[p*pc2p_pkg::PLANE_W +: pc2p_pkg::PLANE_W]
          !== out_tdata[p*pc2p_pkg::PLANE_W +: pc2p_pkg::PLANE_W])
        note_failure($sformatf("%s expected %h got %h", plane_name[p],
                               want.words[p*pc2p_pkg::PLANE_W +: pc2p_pkg::PLANE_W],
                               out_tdata[p*pc2p_pkg::PLANE_W +: pc2p_pkg::PLANE_W]));
    if (want.overflow !== out_tuser)
      note_failure($sformatf("palette_overflow expected %b got %b", want.overflow, out_tuser));
  endfunction

  // receiver with random stall bursts
  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else if (!calm && rst_n && $urandom_range(0, 4) == 0) begin
      out_hold = $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result monitor and watchdog
  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      check_group();
    end
  end

  task automatic test_unused_opcode();
    send_request(OP_UNUSED, 12'hFFF, 4'hF);
  endtask

  // duplicate colors, lock over a used slot, extreme slots
  task automatic test_lock_rules();
    send_request(pc2p_pkg::OP_LOCK, 12'hFFF, 4'hF);
    send_request(pc2p_pkg::OP_LOCK, 12'h000, 4'h0);
    send_request(pc2p_pkg::OP_LOCK, 12'h000, 4'h3);
    send_request(pc2p_pkg::OP_LOCK, 12'hABC, 4'h0);
  endtask

  // fills the free slots, then overflows on the last pixel of the group
  task automatic test_fill_and_overflow();
    send_request(pc2p_pkg::OP_PIXEL, 12'hFFF, 4'h0);
    send_request(pc2p_pkg::OP_PIXEL, 12'hABC, 4'h5);
    for (int i = 0; i < 13; i++)
      send_request(pc2p_pkg::OP_PIXEL, pc2p_pkg::PIXEL_W'(12'h101 + i), 4'hA);
    send_request(pc2p_pkg::OP_PIXEL, 12'h555, 4'h0);
  endtask

  task automatic test_clear();
    send_request(pc2p_pkg::OP_CLEAR, 12'hFFF, 4'hF);
    wait_for_results();
  endtask

  // scanlines of random content: mostly well-formed groups, some noise
  task automatic test_random_scanlines(int unsigned budget);
    logic [pc2p_pkg::PIXEL_W-1:0] pool [POOL_MAX];
    logic [pc2p_pkg::PIXEL_W-1:0] color;
    int unsigned                  pool_size, groups, start, noise;
    start = n_requests;
    while (n_requests - start < budget) begin
      pool_size = $urandom_range(2, POOL_MAX);  // more than 16 colors overflows
      for (int i = 0; i < POOL_MAX; i++) pool[i] = pc2p_pkg::PIXEL_W'($urandom);
      if ($urandom_range(0, 3) != 0)
        send_request(pc2p_pkg::OP_CLEAR, pc2p_pkg::PIXEL_W'($urandom),
                     pc2p_pkg::SLOT_W'($urandom));
      repeat ($urandom_range(0, 3))
        send_request(pc2p_pkg::OP_LOCK, pool[$urandom_range(0, pool_size - 1)],
                     pc2p_pkg::SLOT_W'($urandom));
      groups = $urandom_range(1, 4);
      for (int k = 0; k < groups * GROUP; k++) begin
        noise = $urandom_range(0, 59);
        if (noise == 0)
          send_request(OP_UNUSED, pc2p_pkg::PIXEL_W'($urandom), pc2p_pkg::SLOT_W'($urandom));
        else if (noise == 1)
          send_request(pc2p_pkg::OP_LOCK, pool[$urandom_range(0, pool_size - 1)],
                       pc2p_pkg::SLOT_W'($urandom));
        else if (noise == 2)  // breaks the group
          send_request(pc2p_pkg::OP_CLEAR, pc2p_pkg::PIXEL_W'($urandom),
                       pc2p_pkg::SLOT_W'($urandom));
        if ($urandom_range(0, 9) == 0) color = pc2p_pkg::PIXEL_W'($urandom);
        else color = pool[$urandom_range(0, pool_size - 1)];
        send_request(pc2p_pkg::OP_PIXEL, color, pc2p_pkg::SLOT_W'($urandom));
      end
    end
  endtask

  initial begin
    clear_palette();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unused_opcode();
    test_lock_rules();
    test_fill_and_overflow();
    test_clear();
    test_random_scanlines(1400);
    wait_for_results();
    calm = 1'b1;
    test_random_scanlines(400);
    wait_for_results();
    repeat (8) @(posedge clk);
    if (pending_groups.size() != 0)
      note_failure($sformatf("%0d groups never arrived", pending_groups.size()));
    $display("Sent %0d pixels, %0d locks, %0d clears and %0d ignored requests;",
             n_pixels, n_locks, n_clears, n_ignored);
    $display("checked %0d plane groups, %0d of them after palette overflow, %0d errors.",
             n_groups, n_ovf_groups, errors);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
src/pc2p_pkg.sv
src/palette_chunky_to_planar_core.sv
tb/tb.sv
